FILE: rtl/rrfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrfd_pkg;

  // Frame limits: pixels beyond these are not counted
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Pixel field widths
  localparam int COLOR_W = 8;
  localparam int COORD_W = 10;

  // First rectangle (change)
  localparam logic [COORD_W-1:0] CH_X0 = 10'd80;
  localparam logic [COORD_W-1:0] CH_X1 = 10'd96;
  localparam logic [COORD_W-1:0] CH_Y0 = 10'd48;
  localparam logic [COORD_W-1:0] CH_Y1 = 10'd60;

  // Second rectangle (turn)
  localparam logic [COORD_W-1:0] TU_X0 = 10'd90;
  localparam logic [COORD_W-1:0] TU_X1 = 10'd112;
  localparam logic [COORD_W-1:0] TU_Y0 = 10'd48;
  localparam logic [COORD_W-1:0] TU_Y1 = 10'd72;

  // Smallest frame that gets evaluated: last pixel at or beyond these
  localparam logic [COORD_W-1:0] MIN_LAST_ROW = 10'd72;
  localparam logic [COORD_W-1:0] MIN_LAST_COL = 10'd112;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW_MAX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_THR       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_REQ     = 3'd6;

  // Register reset values
  localparam logic [7:0] HUE_LOW_MAX_RST  = 8'd10;
  localparam logic [7:0] HUE_HIGH_MIN_RST = 8'd170;
  localparam logic [7:0] SAT_MIN_RST      = 8'd120;
  localparam logic [7:0] VAL_MIN_RST      = 8'd70;
  localparam logic [7:0] CHANGE_THR_RST   = 8'd35;
  localparam logic [9:0] TURN_THR_RST     = 10'd300;
  localparam logic [3:0] FRAMES_REQ_RST   = 4'd3;

  // Divider sizing: numerators below 2^17, quotients below 2^9
  localparam int DIV_NUM_W = 17;
  localparam int DIV_Q_W   = 9;

  // Hue wraps at 180
  localparam logic [DIV_Q_W-1:0] HUE_WRAP = 9'd180;

  // Count limits
  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CH_CNT_MAX = 10'd255;
  localparam logic [CNT_W-1:0] TU_CNT_MAX = 10'd1023;

  // One state memory entry per rectangle
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [3:0]       streak;
  } rrfd_entry_t;

  localparam rrfd_entry_t ENTRY_RESET = '{count: '0, streak: FRAMES_REQ_RST};

  localparam logic ENT_CHANGE = 1'b0;
  localparam logic ENT_TURN   = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/rrfd_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// The caller guarantees quotient < 2^DIV_Q_W.
module rrfd_div
  import rrfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_Q_W-1:0]   den,
  output logic                      done,
  output logic [DIV_Q_W-1:0]        quot
);

  localparam int CNT_BITS = $clog2(DIV_Q_W);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_Q_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [DIV_NUM_W-1:0] rem_r;
  logic [DIV_NUM_W:0]   dsh_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic                 fits;

  // Trial subtract against the shifted divisor
  assign fits = {1'b0, rem_r} >= dsh_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {1'b0, den, {(DIV_Q_W-1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r[DIV_NUM_W-1:0];
      end
      dsh_r <= {1'b0, dsh_r[DIV_NUM_W:1]};
      q_r   <= {q_r[DIV_Q_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

FILE: rtl/red_roi_frame_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Red sign detector on a BGR pixel stream. Each pixel is turned into HSV
// (hue 0..179, rounded), tested against two red hue bands plus minimum
// saturation and value, and counted in two fixed rectangles. On the last
// pixel of a frame of at least 73 rows by 113 columns one result transaction
// carries both counts and the two one-shot flags that fire when a rectangle's
// streak of passing frames runs out. Smaller frames give no result. No new
// pixel is accepted until the current one is finished; a pixel closing a
// frame with a result also passes the emit state (plus any wait on the
// output register). Each pixel uses the shared one-bit-per-cycle divider
// twice (saturation, then hue), then one read-modify-write per rectangle
// on the state memory. Registers must be written through the cfg port only
// while the block is idle; the block does not enforce this. A new
// frames_required value takes effect at the next streak reload.
module red_roi_frame_detector
  import rrfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Pixel input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COLOR_W-1:0]    in_blue,
  input  wire logic [COLOR_W-1:0]    in_green,
  input  wire logic [COLOR_W-1:0]    in_red,
  input  wire logic [COORD_W-1:0]    in_column,
  input  wire logic [COORD_W-1:0]    in_row,
  input  wire logic                  in_end_of_frame,
  // Frame result
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_change_flag,
  output logic                       out_turn_flag,
  output logic [7:0]                 out_change_pixels,
  output logic [CNT_W-1:0]           out_turn_pixels,
  // Register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SAT,
    S_HUE,
    S_UPD0,
    S_UPD1,
    S_EMIT
  } state_t;

  // Configuration registers
  logic [7:0] hue_low_max_r, hue_high_min_r, sat_min_r, val_min_r, change_thr_r;
  logic [9:0] turn_thr_r;
  logic [3:0] frames_req_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_max_r  <= HUE_LOW_MAX_RST;
      hue_high_min_r <= HUE_HIGH_MIN_RST;
      sat_min_r      <= SAT_MIN_RST;
      val_min_r      <= VAL_MIN_RST;
      change_thr_r   <= CHANGE_THR_RST;
      turn_thr_r     <= TURN_THR_RST;
      frames_req_r   <= FRAMES_REQ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HUE_LOW_MAX:  hue_low_max_r  <= cfg_data[7:0];
        REG_HUE_HIGH_MIN: hue_high_min_r <= cfg_data[7:0];
        REG_SAT_MIN:      sat_min_r      <= cfg_data[7:0];
        REG_VAL_MIN:      val_min_r      <= cfg_data[7:0];
        REG_CHANGE_THR:   change_thr_r   <= cfg_data[7:0];
        REG_TURN_THR:     turn_thr_r     <= cfg_data[9:0];
        REG_FRAMES_REQ:   frames_req_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Pipeline and output registers
  state_t               state_r, state_nxt;
  logic [COLOR_W-1:0]   b_r, g_r, r_r;
  logic [COORD_W-1:0]   col_r, row_r;
  logic                 eof_r;
  logic [7:0]           v_r, d_r, sat_r;
  logic [10:0]          n_r;
  logic [1:0]           hit_r;
  logic                 chg_flag_r, tu_flag_r;
  logic [7:0]           chg_cnt_r;
  logic [CNT_W-1:0]     tu_cnt_r;
  logic                 out_valid_r, out_change_flag_r, out_turn_flag_r;
  logic [7:0]           out_change_pixels_r;
  logic [CNT_W-1:0]     out_turn_pixels_r;

  logic                 in_fire;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Max, min, spread and hue sector numerator
  logic [7:0]  v_c, m_c, d_c;
  logic [10:0] n_c;
  always_comb begin
    v_c = b_r;
    m_c = b_r;
    if (g_r > v_c) v_c = g_r;
    if (r_r > v_c) v_c = r_r;
    if (g_r < m_c) m_c = g_r;
    if (r_r < m_c) m_c = r_r;
    d_c = v_c - m_c;
    if (v_c == r_r) begin
      if (g_r >= b_r) n_c = 11'(g_r) - 11'(b_r);
      else            n_c = 11'(g_r) + 11'(d_c) * 11'd6 - 11'(b_r);
    end else if (v_c == g_r) begin
      n_c = 11'(b_r) + 11'(d_c) * 11'd2 - 11'(r_r);
    end else begin
      n_c = 11'(r_r) + 11'(d_c) * 11'd4 - 11'(g_r);
    end
  end

  // Shared divider: saturation in S_PREP, hue when saturation is done
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_Q_W-1:0]   div_den, div_quot;

  assign div_start = (state_r == S_PREP) || (state_r == S_SAT && div_done);
  always_comb begin
    if (state_r == S_PREP) begin
      div_num = DIV_NUM_W'(d_c) * DIV_NUM_W'(510) + DIV_NUM_W'(v_c);
      div_den = {v_c, 1'b0};
    end else begin
      div_num = DIV_NUM_W'(n_r) * DIV_NUM_W'(60) + DIV_NUM_W'(d_r);
      div_den = {d_r, 1'b0};
    end
  end

  rrfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Hue wrap and red test
  logic [DIV_Q_W-1:0] hue_c;
  logic               red_c, in_frame_c, in_ch_c, in_tu_c, big_c;
  always_comb begin
    if (d_r == 8'd0)              hue_c = '0;
    else if (div_quot >= HUE_WRAP) hue_c = div_quot - HUE_WRAP;
    else                           hue_c = div_quot;
    red_c = ((hue_c <= {1'b0, hue_low_max_r}) || (hue_c >= {1'b0, hue_high_min_r}))
            && (sat_r >= sat_min_r) && (v_r >= val_min_r);
    in_frame_c = ({22'd0, col_r} < 32'(MAX_WIDTH)) && ({22'd0, row_r} < 32'(MAX_HEIGHT));
    in_ch_c = (col_r >= CH_X0) && (col_r <= CH_X1) && (row_r >= CH_Y0) && (row_r <= CH_Y1);
    in_tu_c = (col_r >= TU_X0) && (col_r <= TU_X1) && (row_r >= TU_Y0) && (row_r <= TU_Y1);
    big_c   = (row_r >= MIN_LAST_ROW) && (col_r >= MIN_LAST_COL);
  end

  // State memory: one entry per rectangle, valid bits stand for reset
  rrfd_entry_t mem_r [2];
  logic [1:0]  mem_vld_r;
  rrfd_entry_t rd_data_r;
  logic        rd_vld_r;
  logic        rd_addr, wr_addr, mem_we;
  rrfd_entry_t wr_data;

  assign rd_addr = (state_r == S_UPD0) ? ENT_TURN : ENT_CHANGE;
  assign wr_addr = (state_r == S_UPD1) ? ENT_TURN : ENT_CHANGE;
  assign mem_we  = (state_r == S_UPD0) || (state_r == S_UPD1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
    rd_vld_r  <= mem_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (mem_we) begin
      mem_vld_r[wr_addr] <= 1'b1;
    end
  end

  // Entry update: count the pixel, judge the frame at its end
  rrfd_entry_t      cur_c;
  logic             ent_c, hit_c, flag_c;
  logic [CNT_W-1:0] cnt_max_c, thr_c, cnt_new_c;
  logic [3:0]       reload_c;
  always_comb begin
    cur_c     = rd_vld_r ? rd_data_r : ENTRY_RESET;
    ent_c     = (state_r == S_UPD1);
    hit_c     = hit_r[ent_c];
    cnt_max_c = ent_c ? TU_CNT_MAX : CH_CNT_MAX;
    thr_c     = ent_c ? turn_thr_r : {2'b00, change_thr_r};
    reload_c  = (frames_req_r == 4'd0) ? 4'd1 : frames_req_r;
    cnt_new_c = (hit_c && cur_c.count != cnt_max_c) ? cur_c.count + 1'b1 : cur_c.count;
    wr_data   = '{count: cnt_new_c, streak: cur_c.streak};
    flag_c    = 1'b0;
    if (eof_r) begin
      wr_data.count = '0;
      if (big_c && cur_c.streak != 4'd0) begin
        if (cnt_new_c > thr_c) begin
          wr_data.streak = cur_c.streak - 1'b1;
          flag_c         = (cur_c.streak == 4'd1);
        end else begin
          wr_data.streak = reload_c;
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_PREP;
      S_PREP: state_nxt = S_SAT;
      S_SAT:  if (div_done) state_nxt = S_HUE;
      S_HUE:  if (div_done) state_nxt = S_UPD0;
      S_UPD0: state_nxt = S_UPD1;
      S_UPD1: state_nxt = (eof_r && big_c) ? S_EMIT : S_IDLE;
      S_EMIT: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Result register: load on emit, drop once taken
      if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            b_r   <= in_blue;
            g_r   <= in_green;
            r_r   <= in_red;
            col_r <= in_column;
            row_r <= in_row;
            eof_r <= in_end_of_frame;
          end
        end
        S_PREP: begin
          v_r <= v_c;
          d_r <= d_c;
          n_r <= n_c;
        end
        S_SAT: begin
          if (div_done) begin
            sat_r <= (v_r == 8'd0) ? 8'd0 : div_quot[7:0];
          end
        end
        S_HUE: begin
          if (div_done) begin
            hit_r[ENT_CHANGE] <= in_frame_c && red_c && in_ch_c;
            hit_r[ENT_TURN]   <= in_frame_c && red_c && in_tu_c;
          end
        end
        S_UPD0: begin
          chg_flag_r <= flag_c;
          chg_cnt_r  <= cnt_new_c[7:0];
        end
        S_UPD1: begin
          tu_flag_r <= flag_c;
          tu_cnt_r  <= cnt_new_c;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_change_flag_r   <= chg_flag_r;
            out_turn_flag_r     <= tu_flag_r;
            out_change_pixels_r <= chg_cnt_r;
            out_turn_pixels_r   <= tu_cnt_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_change_flag   = out_change_flag_r;
  assign out_turn_flag     = out_turn_flag_r;
  assign out_change_pixels = out_change_pixels_r;
  assign out_turn_pixels   = out_turn_pixels_r;

`ifndef SYNTH
  // Divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SAT || state_r == S_HUE))
    else $error("divider done outside its wait states");

  // State memory is written only in the update cycles
  a_mem_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_UPD0 || state_r == S_UPD1))
    else $error("state memory written outside update");

  // A new result comes only from the emit state
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside emit");

  // An accepted pixel starts the saturation division
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_PREP && div_start))
    else $error("accepted pixel did not start processing");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rrfd_pkg::*;

  // Fixed rectangles and minimum frame size, as the predictor sees them
  localparam int CHG_X_LO = 80;
  localparam int CHG_X_HI = 96;
  localparam int CHG_Y_LO = 48;
  localparam int CHG_Y_HI = 60;
  localparam int TRN_X_LO = 90;
  localparam int TRN_X_HI = 112;
  localparam int TRN_Y_LO = 48;
  localparam int TRN_Y_HI = 72;
  localparam int LAST_ROW_MIN = 72;
  localparam int LAST_COL_MIN = 112;
  localparam int CHG_SAT = 255;
  localparam int TRN_SAT = 1023;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    logic       change_flag;
    logic       turn_flag;
    logic [7:0] change_pixels;
    logic [9:0] turn_pixels;
  } frame_result_t;

  // Tracks the detector state and the frame results still owed
  class red_frame_scoreboard;
    logic [7:0]    hue_lo, hue_hi, sat_floor, val_floor, change_thr;
    logic [9:0]    turn_thr;
    logic [3:0]    frames_needed;
    int            change_cnt, turn_cnt;
    logic [3:0]    change_run, turn_run;
    frame_result_t pending[$];
    int            errors;
    int            frames_checked;

    function new();
      hue_lo        = HUE_LOW_MAX_RST;
      hue_hi        = HUE_HIGH_MIN_RST;
      sat_floor     = SAT_MIN_RST;
      val_floor     = VAL_MIN_RST;
      change_thr    = CHANGE_THR_RST;
      turn_thr      = TURN_THR_RST;
      frames_needed = FRAMES_REQ_RST;
      change_cnt    = 0;
      turn_cnt      = 0;
      change_run    = FRAMES_REQ_RST;
      turn_run      = FRAMES_REQ_RST;
      errors        = 0;
      frames_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HUE_LOW_MAX:  hue_lo = data[7:0];
        REG_HUE_HIGH_MIN: hue_hi = data[7:0];
        REG_SAT_MIN:      sat_floor = data[7:0];
        REG_VAL_MIN:      val_floor = data[7:0];
        REG_CHANGE_THR:   change_thr = data[7:0];
        REG_TURN_THR:     turn_thr = data[9:0];
        REG_FRAMES_REQ:   frames_needed = data[3:0];
        default: ;
      endcase
    endfunction

    // HSV conversion with rounded hue/saturation, then band test
    function bit pixel_is_red(int b, int g, int r);
      int v, m, d, s, h, n;
      v = b;
      m = b;
      if (g > v) v = g;
      if (r > v) v = r;
      if (g < m) m = g;
      if (r < m) m = r;
      d = v - m;
      s = (v == 0) ? 0 : (510 * d + v) / (2 * v);
      if (d == 0) begin
        h = 0;
      end else begin
        if (v == r) n = (g >= b) ? (g - b) : (g + 6 * d - b);
        else if (v == g) n = b + 2 * d - r;
        else n = r + 4 * d - g;
        h = (60 * n + d) / (2 * d);
        if (h >= 180) h -= 180;
      end
      return (h <= int'(hue_lo) || h >= int'(hue_hi)) &&
             s >= int'(sat_floor) && v >= int'(val_floor);
    endfunction

    // Streak update: pass counts down, miss reloads, zero sticks
    function bit advance_run(logic [3:0] run, int count, int thr, output logic [3:0] next_run);
      if (run == 4'd0) begin
        next_run = 4'd0;
        return 1'b0;
      end
      if (count > thr) begin
        next_run = run - 4'd1;
        return next_run == 4'd0;
      end
      next_run = (frames_needed == 4'd0) ? 4'd1 : frames_needed;
      return 1'b0;
    endfunction

    function void take_pixel(int b, int g, int r, int x, int y, bit eof);
      frame_result_t res;
      if (x < MAX_WIDTH && y < MAX_HEIGHT && pixel_is_red(b, g, r)) begin
        if (x >= CHG_X_LO && x <= CHG_X_HI && y >= CHG_Y_LO && y <= CHG_Y_HI &&
            change_cnt < CHG_SAT)
          change_cnt++;
        if (x >= TRN_X_LO && x <= TRN_X_HI && y >= TRN_Y_LO && y <= TRN_Y_HI &&
            turn_cnt < TRN_SAT)
          turn_cnt++;
      end
      if (!eof) return;
      // Frame too small: drop counts, streaks untouched
      if (y >= LAST_ROW_MIN && x >= LAST_COL_MIN) begin
        res.change_flag   = advance_run(change_run, change_cnt, int'(change_thr), change_run);
        res.turn_flag     = advance_run(turn_run, turn_cnt, int'(turn_thr), turn_run);
        res.change_pixels = change_cnt[7:0];
        res.turn_pixels   = turn_cnt[9:0];
        pending.push_back(res);
      end
      change_cnt = 0;
      turn_cnt   = 0;
    endfunction

    function void mismatch(string field, logic [9:0] want, logic [9:0] got);
      errors++;
      // keep the log readable on a badly broken build
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_frame(logic cf, logic tf, logic [7:0] cp, logic [9:0] tp);
      frame_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("result with nothing pending: change_pixels %0d, turn_pixels %0d", cp, tp);
        return;
      end
      want = pending.pop_front();
      frames_checked++;
      if (cf !== want.change_flag)
        mismatch("change_flag", 10'(want.change_flag), 10'(cf));
      if (tf !== want.turn_flag)
        mismatch("turn_flag", 10'(want.turn_flag), 10'(tf));
      if (cp !== want.change_pixels)
        mismatch("change_pixels", 10'(want.change_pixels), 10'(cp));
      if (tp !== want.turn_pixels) mismatch("turn_pixels", want.turn_pixels, tp);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COLOR_W-1:0]    in_blue = '0;
  logic [COLOR_W-1:0]    in_green = '0;
  logic [COLOR_W-1:0]    in_red = '0;
  logic [COORD_W-1:0]    in_column = '0;
  logic [COORD_W-1:0]    in_row = '0;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_change_flag;
  logic                  out_turn_flag;
  logic [7:0]            out_change_pixels;
  logic [CNT_W-1:0]      out_turn_pixels;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  red_frame_scoreboard sb = new();
  bit jitter_on = 1'b1;
  int pixels_sent = 0;
  int stall_left = 0;

  red_roi_frame_detector DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_change_flag   (out_change_flag),
    .out_turn_flag     (out_turn_flag),
    .out_change_pixels (out_change_pixels),
    .out_turn_pixels   (out_turn_pixels),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_frame(out_change_flag, out_turn_flag, out_change_pixels, out_turn_pixels);
      if (in_valid && in_ready)
        sb.take_pixel(int'(in_blue), int'(in_green), int'(in_red), int'(in_column),
                      int'(in_row), in_end_of_frame);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Result backpressure in random bursts
  always @(negedge clk) begin
    if (!jitter_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #8_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // One pixel transaction; called at a falling edge, returns at one
  task automatic push_pixel(int b, int g, int r, int x, int y, bit eof);
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_blue         = b[7:0];
    in_green        = g[7:0];
    in_red          = r[7:0];
    in_column       = x[9:0];
    in_row          = y[9:0];
    in_end_of_frame = eof;
    in_valid        = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_index = idx;
    cfg_data  = data[CFG_DATA_W-1:0];
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(int hlo, int hhi, int sat, int val, int cthr, int tthr, int fr);
    write_cfg(REG_HUE_LOW_MAX, hlo);
    write_cfg(REG_HUE_HIGH_MIN, hhi);
    write_cfg(REG_SAT_MIN, sat);
    write_cfg(REG_VAL_MIN, val);
    write_cfg(REG_CHANGE_THR, cthr);
    write_cfg(REG_TURN_THR, tthr);
    write_cfg(REG_FRAMES_REQ, fr);
  endtask

  // Stop sending, let every owed result out, then cover the pixel latency
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void pick_color(output int b, output int g, output int r);
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(60, 255);
      g = $urandom_range(0, r / 3);
      b = $urandom_range(0, r / 3);
    end else begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end
  endfunction

  // A frame: mostly pixels around the rectangles, some noise, then a closing pixel
  task automatic random_frame();
    int len, kind, x, y, b, g, r;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 60) : $urandom_range(0, 30);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        x = $urandom_range(78, 114);
        y = $urandom_range(46, 74);
      end else begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
      end
      pick_color(b, g, r);
      push_pixel(b, g, r, x, y, kind == 9 && $urandom_range(0, 1) == 1);
    end
    if ($urandom_range(0, 7) == 0) begin
      // undersized frame
      if ($urandom_range(0, 1) == 1) begin
        x = $urandom_range(0, LAST_COL_MIN - 1);
        y = $urandom_range(0, 1023);
      end else begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, LAST_ROW_MIN - 1);
      end
    end else begin
      x = ($urandom_range(0, 3) == 0) ? LAST_COL_MIN : $urandom_range(LAST_COL_MIN, 1023);
      y = ($urandom_range(0, 3) == 0) ? LAST_ROW_MIN : $urandom_range(LAST_ROW_MIN, 1023);
    end
    pick_color(b, g, r);
    push_pixel(b, g, r, x, y, 1'b1);
  endtask

  task automatic run_phase(int n_pixels);
    int start;
    start = pixels_sent;
    while (pixels_sent - start < n_pixels) random_frame();
    wait_drained();
  endtask

  task automatic random_settings();
    apply_settings($urandom_range(0, 40), $urandom_range(140, 179), $urandom_range(0, 200),
                   $urandom_range(0, 150), $urandom_range(0, 10), $urandom_range(0, 16),
                   $urandom_range(1, 5));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pixels under reset settings
    push_pixel(0, 0, 0, 80, 48, 1'b0);         // black
    push_pixel(255, 255, 255, 96, 60, 1'b0);   // white, no chroma
    push_pixel(0, 0, 255, 80, 60, 1'b0);       // pure red, corner of first box
    push_pixel(1, 0, 255, 90, 48, 1'b0);       // hue rounds to 180, wraps to 0
    push_pixel(0, 255, 0, 96, 48, 1'b0);       // pure green
    push_pixel(255, 0, 0, 112, 72, 1'b0);      // pure blue
    push_pixel(0, 0, 255, 79, 50, 1'b0);       // just left of first box
    push_pixel(0, 0, 255, 97, 50, 1'b0);       // second box only
    push_pixel(0, 0, 255, 100, 47, 1'b0);      // above both
    push_pixel(0, 0, 255, 100, 61, 1'b0);      // below first box
    push_pixel(0, 0, 255, 113, 60, 1'b0);      // right of second box
    push_pixel(0, 0, 255, 100, 73, 1'b0);      // below second box
    push_pixel(0, 0, 255, 89, 72, 1'b0);
    push_pixel(0, 0, 255, 111, 1023, 1'b1);    // undersized frame, no result
    push_pixel(135, 135, 255, 85, 55, 1'b0);   // saturation exactly at floor
    push_pixel(0, 0, 70, 85, 56, 1'b0);        // value exactly at floor
    push_pixel(0, 0, 69, 85, 57, 1'b0);        // value one below
    push_pixel(0, 85, 255, 95, 58, 1'b0);      // hue at top of low band
    push_pixel(0, 90, 255, 95, 59, 1'b0);      // hue just above low band
    push_pixel(89, 0, 255, 92, 50, 1'b0);      // hue at bottom of high band
    push_pixel(90, 0, 255, 92, 51, 1'b0);      // hue just below high band
    push_pixel(0, 0, 255, 112, 72, 1'b1);      // smallest evaluated frame
    push_pixel(255, 0, 255, 1023, 1023, 1'b1); // largest corner
    push_pixel(0, 0, 255, 112, 71, 1'b1);      // one row short
    wait_drained();

    // Strict saturation, value and thresholds, all hues pass, long streaks
    apply_settings(179, 0, 255, 255, 221, 575, 15);
    run_phase(100);
    // Zero streak length reloads as one
    apply_settings(10, 170, 60, 40, 8, 12, 0);
    run_phase(120);
    repeat (4) begin
      random_settings();
      run_phase(100);
    end

    // First box count pinned at its maximum by a repeated coordinate
    apply_settings(10, 170, 120, 70, 221, 575, 2);
    repeat (270) push_pixel(0, 0, 255, 93, 50, 1'b0);
    push_pixel(0, 0, 255, 112, 72, 1'b1);
    wait_drained();

    // Loose floors and thresholds, narrowest hue bands: any pass fires at once
    apply_settings(0, 179, 0, 0, 0, 0, 1);
    run_phase(80);

    // Final stretch at full rate
    random_settings();
    jitter_on = 1'b0;
    run_phase(150);

    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rrfd_pkg.sv
rtl/rrfd_div.sv
rtl/red_roi_frame_detector.sv
tb/tb_top.sv
